@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL file that carries concurrent checks.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the synchronous reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication whose consequent must hold in the cycle after the antecedent.
`define BSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfp_pkg
// Types and event codes shared by the buffered serial FIFO pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsfp_pkg;

    // Event codes carried in the action field.
    localparam logic [2:0] ACT_HOST_WR  = 3'd0;
    localparam logic [2:0] ACT_HOST_RD  = 3'd1;
    localparam logic [2:0] ACT_TX_READY = 3'd2;
    localparam logic [2:0] ACT_LINE_RX  = 3'd3;
    localparam logic [2:0] ACT_STATUS   = 3'd4;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_in;
    } t_bsfp_in;

    typedef struct packed {
        logic       ok;
        logic [7:0] byte_out;
        logic       send_valid;
        logic       tx_request;
        logic [7:0] tx_used;
        logic [7:0] tx_free;
        logic [7:0] rx_used;
        logic [7:0] rx_free;
    } t_bsfp_out;

    // Qualified pointer moves for one FIFO.
    typedef struct packed {
        logic push;
        logic pop;
    } t_bsfp_req;

    // Occupancy flags of one FIFO.
    typedef struct packed {
        logic empty;
        logic full;
    } t_bsfp_stat;

endpackage

`default_nettype wire

@@ sv/buffered_serial_fifo_pair_core.sv @@
// ----------------------------------------------------------------------------
// buffered_serial_fifo_pair_core
// Transmit and receive byte FIFOs between a host and a serial line.
// ----------------------------------------------------------------------------
// Each event (host write, host read, transmitter ready, line byte received,
// status) produces one result. The block takes one event per clock cycle
// while the result register is not stalled; a result passes through the
// first stage with the registered read of the FIFO RAM, then the result
// register. Pointers move at the transfer of the event, so back-to-back
// events always see the FIFO state left by the one before. Each FIFO holds
// at most DEPTH-1 bytes. The RAM contents are not cleared after reset; a
// pop only ever reads a slot that a push has written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module buffered_serial_fifo_pair_core
    import bsfp_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_bsfp_in  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_bsfp_out      o_out_data
);

    localparam int PW = $clog2(DEPTH);

    logic          accept;
    logic          s1_adv;
    t_bsfp_req     tx_req, rx_req;
    t_bsfp_stat    tx_stat, rx_stat;
    logic [PW-1:0] tx_head, tx_tail, rx_head, rx_tail;
    logic [7:0]    tx_used, tx_free, rx_used, rx_free;
    logic [7:0]    tx_rdata, rx_rdata;

    logic          n_ok, n_send, n_sel_rx, n_sel_tx;
    logic          r_tx_pending, n_tx_pending;

    logic          r_s1_valid;
    logic          r_s1_ok, r_s1_send, r_s1_sel_rx, r_s1_sel_tx;

    logic          r_out_valid;
    t_bsfp_out     r_out;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = s1_adv || !r_s1_valid;
    assign accept     = i_in_valid && o_in_ready;

    // Event decode against the current pointer state.
    always_comb begin
        tx_req       = '0;
        rx_req       = '0;
        n_ok         = 1'b1;
        n_send       = 1'b0;
        n_sel_rx     = 1'b0;
        n_sel_tx     = 1'b0;
        n_tx_pending = r_tx_pending;
        unique case (i_in_data.action)
            ACT_HOST_WR: begin
                tx_req.push  = accept && !tx_stat.full;
                n_ok         = !tx_stat.full;
                n_tx_pending = 1'b1;
            end
            ACT_HOST_RD: begin
                rx_req.pop = accept && !rx_stat.empty;
                n_ok       = !rx_stat.empty;
                n_sel_rx   = !rx_stat.empty;
            end
            ACT_TX_READY: begin
                tx_req.pop = accept && !tx_stat.empty;
                n_ok       = !tx_stat.empty;
                n_send     = !tx_stat.empty;
                n_sel_tx   = !tx_stat.empty;
                if (tx_stat.empty) begin
                    n_tx_pending = 1'b0;
                end
            end
            ACT_LINE_RX: begin
                rx_req.push = accept && !rx_stat.full;
                n_ok        = !rx_stat.full;
            end
            default: begin
                // Status and unused codes leave the state alone.
                n_ok = 1'b1;
            end
        endcase
    end

    bsfp_fifo_ptr #(.DEPTH(DEPTH)) u_tx_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .o_stat  (tx_stat),
        .o_head  (tx_head),
        .o_tail  (tx_tail),
        .o_used  (tx_used),
        .o_free  (tx_free)
    );

    bsfp_fifo_ptr #(.DEPTH(DEPTH)) u_rx_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .o_stat  (rx_stat),
        .o_head  (rx_head),
        .o_tail  (rx_tail),
        .o_used  (rx_used),
        .o_free  (rx_free)
    );

    // A pop never reads the slot being written: it only happens when
    // head and tail differ, and the write goes to the tail.
    bsfp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tx_req.push),
        .i_wr_addr (tx_tail),
        .i_wr_data (i_in_data.byte_in),
        .i_rd_en   (tx_req.pop),
        .i_rd_addr (tx_head),
        .o_rd_data (tx_rdata)
    );

    bsfp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rx_req.push),
        .i_wr_addr (rx_tail),
        .i_wr_data (i_in_data.byte_in),
        .i_rd_en   (rx_req.pop),
        .i_rd_addr (rx_head),
        .o_rd_data (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_pending <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_tx_pending <= n_tx_pending;
            end
            if (o_in_ready) begin
                r_s1_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok     <= n_ok;
            r_s1_send   <= n_send;
            r_s1_sel_rx <= n_sel_rx;
            r_s1_sel_tx <= n_sel_tx;
        end
    end

    // While an event sits in the first stage, the pointer and request
    // registers already hold the state it left behind, and the RAM read
    // data holds until the next accepted pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out.ok         <= r_s1_ok;
            r_out.byte_out   <= r_s1_sel_rx ? rx_rdata :
                                (r_s1_sel_tx ? tx_rdata : 8'd0);
            r_out.send_valid <= r_s1_send;
            r_out.tx_request <= r_tx_pending;
            r_out.tx_used    <= tx_used;
            r_out.tx_free    <= tx_free;
            r_out.rx_used    <= rx_used;
            r_out.rx_free    <= rx_free;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BSFP_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_out_ready, r_s1_valid,
        "first stage lost an event while the result register was stalled")
    `BSFP_ASSERT(a_send_ok, i_clk, i_rst_n,
        !o_out_valid || !o_out_data.send_valid || o_out_data.ok,
        "send_valid without a successful pop")
    `BSFP_ASSERT_NEXT(a_wr_raises_req, i_clk, i_rst_n,
        accept && (i_in_data.action == ACT_HOST_WR), r_tx_pending,
        "host write did not raise the transmit request")
    `BSFP_ASSERT(a_flags_excl, i_clk, i_rst_n,
        !(tx_stat.empty && tx_stat.full) && !(rx_stat.empty && rx_stat.full),
        "FIFO flagged both empty and full")

endmodule

`default_nettype wire

@@ sv/bsfp_ram.sv @@
// ----------------------------------------------------------------------------
// bsfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ sv/bsfp_fifo_ptr.sv @@
// ----------------------------------------------------------------------------
// bsfp_fifo_ptr
// Head and tail pointers of one ring FIFO that keeps one slot empty, with
// full/empty flags and the used and free counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsfp_fifo_ptr
    import bsfp_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_bsfp_req                i_req,
    output t_bsfp_stat                    o_stat,
    output logic      [$clog2(DEPTH)-1:0] o_head,
    output logic      [$clog2(DEPTH)-1:0] o_tail,
    output logic      [7:0]               o_used,
    output logic      [7:0]               o_free
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST    = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [PW-1:0] head_inc, tail_inc;
    logic [PW:0]   diff;
    logic [PW:0]   used_w;
    logic [PW-1:0] used, free;
    logic [PW+7:0] used_ext, free_ext;

    assign head_inc = (r_head == LAST) ? '0 : PW'(r_head + 1'b1);
    assign tail_inc = (r_tail == LAST) ? '0 : PW'(r_tail + 1'b1);

    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.full  = (tail_inc == r_head);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_req.pop) begin
            n_head = head_inc;
        end
        if (i_req.push) begin
            n_tail = tail_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // A negative difference means the tail has wrapped past the end.
    assign diff   = {1'b0, r_tail} - {1'b0, r_head};
    assign used_w = diff[PW] ? (diff + DEPTH_W) : diff;
    assign used   = used_w[PW-1:0];
    assign free   = LAST - used;

    assign used_ext = {8'd0, used};
    assign free_ext = {8'd0, free};
    assign o_used   = used_ext[7:0];
    assign o_free   = free_ext[7:0];

    assign o_head = r_head;
    assign o_tail = r_tail;

endmodule

`default_nettype wire

@@ dv/buffered_serial_fifo_pair_core_tb.sv @@
// ----------------------------------------------------------------------------
// buffered_serial_fifo_pair_core_tb
// Self-checking bench for the transmit and receive byte FIFO pair.
// ----------------------------------------------------------------------------
// A queue of host and line events feeds a valid/ready driver. Every accepted
// event updates a behavioral copy of both rings, which produces the report
// that the block must return. Reports are checked in order, field by field.
// The run covers empty and full FIFOs on both sides, the transmit request
// flag, the unused action codes, and random sender and receiver stalls.
`timescale 1ns / 1ps

module buffered_serial_fifo_pair_core_tb;
    import bsfp_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LINGER      = 16;

    // Action codes above status have no function of their own.
    localparam logic [2:0] ACT_SPARE_MIN = 3'd5;
    localparam logic [2:0] ACT_SPARE_MAX = 3'd7;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_bsfp_in  in_data     = '0;
    logic      out_ready   = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_bsfp_out o_out_data;

    // Behavioral copy of both rings.
    logic [7:0] tx_ring [DEPTH];
    logic [7:0] rx_ring [DEPTH];
    int         tx_rd = 0;
    int         tx_wr = 0;
    int         rx_rd = 0;
    int         rx_wr = 0;
    logic       tx_irq_flag = 1'b0;

    t_bsfp_in  queued_events [$];
    t_bsfp_out pending_reports [$];
    int        events_queued = 0;
    int        events_taken  = 0;
    int        mismatches    = 0;
    int        cycle_count   = 0;
    int        send_idle_pct = 38;
    int        recv_idle_pct = 47;
    logic      in_taken      = 1'b0;

    buffered_serial_fifo_pair_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int ring_next(int p);
        return (p + 1) % DEPTH;
    endfunction

    function automatic int ring_fill(int wr, int rd);
        return (wr - rd + DEPTH) % DEPTH;
    endfunction

    // Applies one event to the ring copies and returns the report it causes.
    function automatic t_bsfp_out next_fifo_report(t_bsfp_in ev);
        t_bsfp_out r;
        int        tu;
        int        ru;
        r = '0;
        r.ok = 1'b1;
        case (ev.action)
            ACT_HOST_WR: begin
                tx_irq_flag = 1'b1;
                if (ring_next(tx_wr) == tx_rd) begin
                    r.ok = 1'b0;
                end else begin
                    tx_ring[tx_wr] = ev.byte_in;
                    tx_wr = ring_next(tx_wr);
                end
            end
            ACT_HOST_RD: begin
                if (rx_rd == rx_wr) begin
                    r.ok = 1'b0;
                end else begin
                    r.byte_out = rx_ring[rx_rd];
                    rx_rd = ring_next(rx_rd);
                end
            end
            ACT_TX_READY: begin
                if (tx_rd == tx_wr) begin
                    r.ok = 1'b0;
                    tx_irq_flag = 1'b0;
                end else begin
                    r.byte_out = tx_ring[tx_rd];
                    r.send_valid = 1'b1;
                    tx_rd = ring_next(tx_rd);
                end
            end
            ACT_LINE_RX: begin
                if (ring_next(rx_wr) == rx_rd) begin
                    r.ok = 1'b0;
                end else begin
                    rx_ring[rx_wr] = ev.byte_in;
                    rx_wr = ring_next(rx_wr);
                end
            end
            default: ;
        endcase
        tu = ring_fill(tx_wr, tx_rd);
        ru = ring_fill(rx_wr, rx_rd);
        r.tx_request = tx_irq_flag;
        r.tx_used    = 8'(tu);
        r.tx_free    = 8'(DEPTH - 1 - tu);
        r.rx_used    = 8'(ru);
        r.rx_free    = 8'(DEPTH - 1 - ru);
        return r;
    endfunction

    task automatic queue_event(input logic [2:0] act, input logic [7:0] b);
        t_bsfp_in ev;
        ev.action  = act;
        ev.byte_in = b;
        queued_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_random_mix(input int count, input int push_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < push_pct)
                queue_event(ACT_HOST_WR, 8'($urandom_range(255)));
            else if (r < 2 * push_pct)
                queue_event(ACT_LINE_RX, 8'($urandom_range(255)));
            else if (r < 2 * push_pct + (90 - 2 * push_pct) / 2)
                queue_event(ACT_HOST_RD, 8'($urandom_range(255)));
            else if (r < 90)
                queue_event(ACT_TX_READY, 8'($urandom_range(255)));
            else
                queue_event(3'($urandom_range(ACT_STATUS, ACT_SPARE_MAX)),
                            8'($urandom_range(255)));
        end
    endtask

    task automatic wait_all_taken();
        while (events_taken != events_queued) @(posedge i_clk);
    endtask

    // Driver: a new transfer is offered only once the previous one has gone.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (queued_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= queued_events.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: the report check runs before the new expectation is queued, so
    // a stray report can never match the event accepted at the same edge.
    always @(posedge i_clk) begin
        t_bsfp_out exp_r;
        logic      bad;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && o_in_ready;
            if (o_out_valid && out_ready) begin
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report: %p", o_out_data);
                end else begin
                    exp_r = pending_reports.pop_front();
                    bad = (o_out_data.ok !== exp_r.ok)
                        || (o_out_data.byte_out !== exp_r.byte_out)
                        || (o_out_data.send_valid !== exp_r.send_valid)
                        || (o_out_data.tx_request !== exp_r.tx_request)
                        || (o_out_data.tx_used !== exp_r.tx_used)
                        || (o_out_data.tx_free !== exp_r.tx_free)
                        || (o_out_data.rx_used !== exp_r.rx_used)
                        || (o_out_data.rx_free !== exp_r.rx_free);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("report mismatch: expected %p", exp_r);
                            $display("                 actual   %p", o_out_data);
                        end
                    end
                end
            end
            if (in_valid && o_in_ready) begin
                pending_reports.push_back(next_fifo_report(in_data));
                events_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int tx_need;
        int rx_need;

        // Empty FIFOs, the request flag, spare codes and extreme bytes.
        queue_event(ACT_STATUS, 8'hFF);
        queue_event(ACT_HOST_RD, 8'hFF);
        queue_event(ACT_TX_READY, 8'hFF);
        queue_event(ACT_HOST_WR, 8'h00);
        queue_event(ACT_HOST_WR, 8'hFF);
        queue_event(ACT_HOST_WR, 8'hA5);
        queue_event(ACT_TX_READY, 8'h00);
        queue_event(ACT_SPARE_MIN, 8'hFF);
        queue_event(3'(ACT_SPARE_MIN + 3'd1), 8'h00);
        queue_event(ACT_SPARE_MAX, 8'h5A);
        queue_event(ACT_TX_READY, 8'h00);
        queue_event(ACT_TX_READY, 8'hFF);
        queue_event(ACT_TX_READY, 8'h00);
        queue_event(ACT_LINE_RX, 8'h00);
        queue_event(ACT_LINE_RX, 8'hFF);
        queue_event(ACT_LINE_RX, 8'h5A);
        queue_event(ACT_HOST_RD, 8'hFF);
        queue_event(ACT_HOST_RD, 8'h00);
        queue_event(ACT_HOST_RD, 8'hFF);
        queue_event(ACT_HOST_RD, 8'h00);
        queue_event(ACT_HOST_WR, 8'h3C);
        queue_event(ACT_LINE_RX, 8'hC3);
        queue_event(ACT_STATUS, 8'h00);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_all_taken();

        // Fill both FIFOs past full, so refusals and drops follow a pointer wrap.
        tx_need = DEPTH - 1 - ring_fill(tx_wr, tx_rd) + 3;
        rx_need = DEPTH - 1 - ring_fill(rx_wr, rx_rd) + 3;
        while (tx_need > 0 || rx_need > 0) begin
            if ($urandom_range(99) < 6) begin
                queue_event(3'($urandom_range(ACT_STATUS, ACT_SPARE_MAX)),
                            8'($urandom_range(255)));
            end else if (tx_need > 0 && (rx_need == 0 || $urandom_range(1) == 1)) begin
                queue_event(ACT_HOST_WR, 8'($urandom_range(255)));
                tx_need--;
            end else begin
                queue_event(ACT_LINE_RX, 8'($urandom_range(255)));
                rx_need--;
            end
        end
        wait_all_taken();

        send_idle_pct = 47;
        recv_idle_pct = 38;
        queue_random_mix(15, 15);
        wait_all_taken();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_mix(15, 22);
        wait_all_taken();

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (LINGER) @(posedge i_clk);

        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/bsfp_pkg.sv
sv/bsfp_ram.sv
sv/bsfp_fifo_ptr.sv
sv/buffered_serial_fifo_pair_core.sv
dv/buffered_serial_fifo_pair_core_tb.sv
